/* hw/rtl/esld_pkg.sv */
package esld_pkg;

   // Field widths
   localparam int EPOCH_W  = 32;
   localparam int ZONE_W   = 17;
   localparam int DAYS_W   = 16;
   localparam int SOD_W    = 17;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DOM_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;

   // Pipeline depth, input register to output register
   localparam int NSTG     = 11;
   // Stages held inside the calendar unit (stage 5 to stage 11)
   localparam int CIV_STG  = 7;

   // Day count at or above this limit is reported as out of range
   localparam int DAY_LIMIT = 24820;

   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;

   // Reciprocals for exact division by constants, (x * M) >> K
   // days = (t >> 7) / 675
   localparam logic [25:0] RCP_DAY   = 26'd50903317;
   localparam int          SH_DAY    = 35;
   // hour = (sod >> 4) / 225
   localparam logic [13:0] RCP_HOUR  = 14'd9321;
   localparam int          SH_HOUR   = 21;
   // minute = (rem >> 2) / 15
   localparam logic [10:0] RCP_MIN   = 11'd1093;
   localparam int          SH_MIN    = 14;
   // doe / 1460 = (doe >> 2) / 365
   localparam logic [16:0] RCP_1460  = 17'd91930;
   localparam int          SH_1460   = 25;
   // yoe = n / 365
   localparam logic [18:0] RCP_YEAR  = 19'd367720;
   localparam int          SH_YEAR   = 27;
   // mp = (5 * doy + 2) / 153
   localparam logic [11:0] RCP_MP    = 12'd3427;
   localparam int          SH_MP     = 19;

   // Calendar constants, counted from 1600-03-01
   localparam int DAYS_TO_1600MAR = 135080;
   localparam int DAYS_PER_ERA    = 146097;
   localparam int DAYS_PER_CENT   = 36524;

   // Time of day plus range flag, carried down the pipe
   typedef struct packed {
      logic               ok;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   second;
   } tod_type;

   // First day of a March-based month within the year: (153 * mp + 2) / 5
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/esld_civil.sv */
module esld_civil (
   input  logic                        clock,
   input  logic [esld_pkg::CIV_STG-1:0] en,
   input  logic [esld_pkg::DAYS_W-1:0]  days,
   output logic [esld_pkg::YEAR_W-1:0]  year,
   output logic [esld_pkg::MONTH_W-1:0] month,
   output logic [esld_pkg::DOM_W-1:0]   day_of_month
);
   import esld_pkg::*;

   // c5: day of era
   logic [17:0] z5;
   logic [17:0] doe5_in, doe5_ff;
   logic        era5_in, era5_ff;

   // c6: century and four-year corrections
   logic [32:0] p6;
   logic [17:0] doe6_ff;
   logic        era6_ff;
   logic [6:0]  a6_in, a6_ff;
   logic [2:0]  b6_in, b6_ff;
   logic        c6_in, c6_ff;

   // c7: corrected day count for year division
   logic [17:0] n7_in, n7_ff;
   logic [17:0] doe7_ff;
   logic        era7_ff;

   // c8: year of era
   logic [36:0] p8;
   logic [8:0]  yoe8_in, yoe8_ff;
   logic [17:0] doe8_ff;
   logic        era8_ff;

   // c9: day of year, base year
   logic [1:0]  cent9;
   logic [17:0] ystart9;
   logic [8:0]  doy9_in, doy9_ff;
   logic [11:0] yb9_in, yb9_ff;

   // c10: March-based month
   logic [10:0] q10;
   logic [22:0] p10;
   logic [3:0]  mp10_in, mp10_ff;
   logic [8:0]  doy10_ff;
   logic [11:0] yb10_ff;

   // c11: final date
   logic [3:0]  m11;
   logic [8:0]  d11;
   logic [YEAR_W-1:0]  year_in,  year_ff;
   logic [MONTH_W-1:0] month_in, month_ff;
   logic [DOM_W-1:0]   dom_in,   dom_ff;

   always_comb begin
      z5      = 18'(days) + 18'(DAYS_TO_1600MAR);
      era5_in = (z5 >= 18'(DAYS_PER_ERA));
      doe5_in = era5_in ? z5 - 18'(DAYS_PER_ERA) : z5;

      p6    = 33'(doe5_ff[17:2]) * 33'(RCP_1460);
      a6_in = p6[SH_1460+6:SH_1460];
      b6_in = 3'(doe5_ff >= 18'(DAYS_PER_CENT))
            + 3'(doe5_ff >= 18'(2 * DAYS_PER_CENT))
            + 3'(doe5_ff >= 18'(3 * DAYS_PER_CENT))
            + 3'(doe5_ff >= 18'(4 * DAYS_PER_CENT));
      c6_in = (doe5_ff == 18'(DAYS_PER_ERA - 1));

      n7_in = doe6_ff - 18'(a6_ff) + 18'(b6_ff) - 18'(c6_ff);

      p8      = 37'(n7_ff) * 37'(RCP_YEAR);
      yoe8_in = p8[SH_YEAR+8:SH_YEAR];

      cent9   = 2'(yoe8_ff >= 9'd100) + 2'(yoe8_ff >= 9'd200) + 2'(yoe8_ff >= 9'd300);
      ystart9 = 18'(yoe8_ff) * 18'd365 + 18'(yoe8_ff[8:2]) - 18'(cent9);
      doy9_in = 9'(doe8_ff - ystart9);
      yb9_in  = 12'(yoe8_ff) + (era8_ff ? 12'd2000 : 12'd1600);

      q10     = 11'(doy9_ff) * 11'd5 + 11'd2;
      p10     = 23'(q10) * 23'(RCP_MP);
      mp10_in = p10[SH_MP+3:SH_MP];

      m11      = (mp10_ff < 4'd10) ? mp10_ff + 4'd3 : mp10_ff - 4'd9;
      d11      = doy10_ff - month_start(mp10_ff) + 9'd1;
      month_in = m11;
      dom_in   = d11[DOM_W-1:0];
      year_in  = yb10_ff + 12'(m11 <= 4'd2);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         doe5_ff <= doe5_in;
         era5_ff <= era5_in;
      end
      if (en[1]) begin
         doe6_ff <= doe5_ff;
         era6_ff <= era5_ff;
         a6_ff   <= a6_in;
         b6_ff   <= b6_in;
         c6_ff   <= c6_in;
      end
      if (en[2]) begin
         n7_ff   <= n7_in;
         doe7_ff <= doe6_ff;
         era7_ff <= era6_ff;
      end
      if (en[3]) begin
         yoe8_ff <= yoe8_in;
         doe8_ff <= doe7_ff;
         era8_ff <= era7_ff;
      end
      if (en[4]) begin
         doy9_ff <= doy9_in;
         yb9_ff  <= yb9_in;
      end
      if (en[5]) begin
         mp10_ff  <= mp10_in;
         doy10_ff <= doy9_ff;
         yb10_ff  <= yb9_ff;
      end
      if (en[6]) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         dom_ff   <= dom_in;
      end
   end

   assign year         = year_ff;
   assign month        = month_ff;
   assign day_of_month = dom_ff;

endmodule

/* hw/rtl/epoch_seconds_to_local_datetime_top.sv */
// Channel | Ports                                   | Word
// req     | req_valid, req_stall                    | req_epoch_seconds
// rsp     | rsp_valid, rsp_stall                    | rsp_ok .. rsp_second
// csr     | csr_wr_en                               | csr_wr_data (zone offset)
//
// Eleven register stages from input to output; one word per cycle sustained while the output is not stalled.
// The stages hold the chain of reciprocal multipliers
// (day split, hour/minute split, year-of-era and month divisions).
// Synchronous reset clears all valid bits and sets the zone offset to zero.
// A stall moves back only as far as the first empty stage, so bubbles close.
module epoch_seconds_to_local_datetime_top #(
   parameter int DAY_LIMIT = esld_pkg::DAY_LIMIT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [esld_pkg::EPOCH_W-1:0] req_epoch_seconds,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [esld_pkg::YEAR_W-1:0]  rsp_year,
   output logic [esld_pkg::MONTH_W-1:0] rsp_month,
   output logic [esld_pkg::DOM_W-1:0]   rsp_day_of_month,
   output logic [esld_pkg::HOUR_W-1:0]  rsp_hour,
   output logic [esld_pkg::MIN_W-1:0]   rsp_minute,
   output logic [esld_pkg::SEC_W-1:0]   rsp_second,
   input  logic                        csr_wr_en,
   input  logic [esld_pkg::ZONE_W-1:0]  csr_wr_data
);
   import esld_pkg::*;

   // Zone offset register
   logic [ZONE_W-1:0] zone_ff;

   // Stage valids and load enables (index 0 is stage 1)
   logic [NSTG-1:0] v_ff, v_in;
   logic [NSTG-1:0] en;

   // s1: shifted time
   logic [31:0] t1_in, t1_ff;
   // s2: day estimate
   logic [50:0] p2;
   logic [15:0] q2_in, q2_ff;
   logic [31:0] t2_ff;
   // s3: remainder
   logic [32:0] p3;
   logic [17:0] rem3_in, rem3_ff;
   logic [15:0] q3_ff;
   // s4: days and seconds of day
   logic [DAYS_W-1:0] days4_in, days4_ff;
   logic [SOD_W-1:0]  secs4_in, secs4_ff;
   logic              ok4_in, ok4_ff;
   // s5: hour
   logic [26:0]       p5;
   logic [HOUR_W-1:0] hr5_in, hr5_ff;
   logic [SOD_W-1:0]  secs5_ff;
   logic              ok5_ff;
   // s6: seconds within hour
   logic [SOD_W-1:0]  hs6;
   logic [11:0]       rs6_in, rs6_ff;
   logic [HOUR_W-1:0] hr6_ff;
   logic              ok6_ff;
   // s7: minute
   logic [20:0]       p7;
   logic [MIN_W-1:0]  min7_in, min7_ff;
   logic [11:0]       rs7_ff;
   logic [HOUR_W-1:0] hr7_ff;
   logic              ok7_ff;
   // s8 to s11: time of day words
   tod_type           tod8_in;
   tod_type           tod_ff [8:NSTG];

   // Calendar outputs at stage 11
   logic [YEAR_W-1:0]  civ_year;
   logic [MONTH_W-1:0] civ_month;
   logic [DOM_W-1:0]   civ_dom;

   // Load enable chain: a stage loads when empty or when the next one loads
   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in = {v_ff[NSTG-2:0], req_valid};
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         zone_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
         if (csr_wr_en) begin
            zone_ff <= csr_wr_data;
         end
      end
   end

   // Datapath next values
   always_comb begin
      t1_in = req_epoch_seconds + {{(32-ZONE_W){zone_ff[ZONE_W-1]}}, zone_ff};

      // upper 25 bits of the shifted time feed the day divider
      p2    = 51'(t1_ff[31:7]) * 51'(RCP_DAY);
      q2_in = p2[SH_DAY+15:SH_DAY];

      p3      = 33'(q2_ff) * 33'(SECS_PER_DAY);
      rem3_in = 18'(t2_ff - p3[31:0]);

      if (rem3_ff >= 18'(SECS_PER_DAY)) begin
         days4_in = q3_ff + 16'd1;
         secs4_in = 17'(rem3_ff - 18'(SECS_PER_DAY));
      end else begin
         days4_in = q3_ff;
         secs4_in = 17'(rem3_ff);
      end
      ok4_in = (days4_in < 16'(DAY_LIMIT));

      p5     = 27'(secs4_ff[16:4]) * 27'(RCP_HOUR);
      hr5_in = p5[SH_HOUR+4:SH_HOUR];

      hs6    = 17'(hr5_ff) * 17'(SECS_PER_HOUR);
      rs6_in = 12'(secs5_ff - hs6);

      p7      = 21'(rs6_ff[11:2]) * 21'(RCP_MIN);
      min7_in = p7[SH_MIN+5:SH_MIN];

      tod8_in.ok     = ok7_ff;
      tod8_in.hour   = hr7_ff;
      tod8_in.minute = min7_ff;
      tod8_in.second = 6'(rs7_ff - 12'(min7_ff) * 12'd60);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t1_ff <= t1_in;
      end
      if (en[1]) begin
         q2_ff <= q2_in;
         t2_ff <= t1_ff;
      end
      if (en[2]) begin
         rem3_ff <= rem3_in;
         q3_ff   <= q2_ff;
      end
      if (en[3]) begin
         days4_ff <= days4_in;
         secs4_ff <= secs4_in;
         ok4_ff   <= ok4_in;
      end
      if (en[4]) begin
         hr5_ff   <= hr5_in;
         secs5_ff <= secs4_ff;
         ok5_ff   <= ok4_ff;
      end
      if (en[5]) begin
         rs6_ff <= rs6_in;
         hr6_ff <= hr5_ff;
         ok6_ff <= ok5_ff;
      end
      if (en[6]) begin
         min7_ff <= min7_in;
         rs7_ff  <= rs6_ff;
         hr7_ff  <= hr6_ff;
         ok7_ff  <= ok6_ff;
      end
      if (en[7]) begin
         tod_ff[8] <= tod8_in;
      end
      for (int s = 9; s <= NSTG; s++) begin
         if (en[s-1]) begin
            tod_ff[s] <= tod_ff[s-1];
         end
      end
   end

   // Calendar date from the day count, stages 5 to 11
   esld_civil u_civil (
      .clock        (clock),
      .en           (en[NSTG-1:NSTG-CIV_STG]),
      .days         (days4_ff),
      .year         (civ_year),
      .month        (civ_month),
      .day_of_month (civ_dom)
   );

   // Output word; out-of-range days give all-zero fields
   assign rsp_valid        = v_ff[NSTG-1];
   assign rsp_ok           = tod_ff[NSTG].ok;
   assign rsp_year         = tod_ff[NSTG].ok ? civ_year  : '0;
   assign rsp_month        = tod_ff[NSTG].ok ? civ_month : '0;
   assign rsp_day_of_month = tod_ff[NSTG].ok ? civ_dom   : '0;
   assign rsp_hour         = tod_ff[NSTG].ok ? tod_ff[NSTG].hour   : '0;
   assign rsp_minute       = tod_ff[NSTG].ok ? tod_ff[NSTG].minute : '0;
   assign rsp_second       = tod_ff[NSTG].ok ? tod_ff[NSTG].second : '0;

endmodule

/* hw/rtl/esld_checker.sv */
module esld_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [esld_pkg::EPOCH_W-1:0] req_epoch_seconds,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_ok,
   input logic [esld_pkg::YEAR_W-1:0]  rsp_year,
   input logic [esld_pkg::MONTH_W-1:0] rsp_month,
   input logic [esld_pkg::DOM_W-1:0]   rsp_day_of_month,
   input logic [esld_pkg::HOUR_W-1:0]  rsp_hour,
   input logic [esld_pkg::MIN_W-1:0]   rsp_minute,
   input logic [esld_pkg::SEC_W-1:0]   rsp_second,
   input logic                        csr_wr_en,
   input logic [esld_pkg::ZONE_W-1:0]  csr_wr_data
);
   import esld_pkg::*;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_year)
         && $stable(rsp_month) && $stable(rsp_day_of_month) && $stable(rsp_hour)
         && $stable(rsp_minute) && $stable(rsp_second))
      else $error("result word changed while stalled");

   // Out-of-range word carries no date or time
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_year == '0 && rsp_month == '0
         && rsp_day_of_month == '0 && rsp_hour == '0 && rsp_minute == '0
         && rsp_second == '0)
      else $error("out-of-range word has non-zero fields");

   // A valid date has a year from 1970 to 2106, a month from 1 to 12 and a day from 1 to 31
   a_date_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_year >= 12'd1970 && rsp_year <= 12'd2106
         && rsp_month >= 4'd1 && rsp_month <= 4'd12
         && rsp_day_of_month >= 5'd1 && rsp_day_of_month <= 5'd31)
      else $error("date out of calendar range");

   // Time of day within its ranges
   a_tod_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |-> rsp_hour <= 5'd23 && rsp_minute <= 6'd59
         && rsp_second <= 6'd59)
      else $error("time of day out of range");

   // Input side never stalls while the whole pipe can drain
   a_no_spurious_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output is free");

endmodule

bind epoch_seconds_to_local_datetime_top esld_checker u_esld_checker (.*);

/* test/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          N_PROBES     = 22;
   localparam int          N_PHASES     = 8;
   localparam int          PHASE_WORDS  = 125;
   localparam int          HOLD_CYCLES  = 150;
   localparam int unsigned LIMIT_SEC    = esld_pkg::DAY_LIMIT * esld_pkg::SECS_PER_DAY;
   localparam int unsigned LAST_OK_SEC  = LIMIT_SEC - 1;

   // One converted date and time, in port order
   typedef struct packed {
      logic                          ok;
      logic [esld_pkg::YEAR_W-1:0]   year;
      logic [esld_pkg::MONTH_W-1:0]  month;
      logic [esld_pkg::DOM_W-1:0]    day_of_month;
      logic [esld_pkg::HOUR_W-1:0]   hour;
      logic [esld_pkg::MIN_W-1:0]    minute;
      logic [esld_pkg::SEC_W-1:0]    second;
   } local_time_type;

   // Directed probe: timestamp, zone offset, and a hand-worked answer where given
   typedef struct packed {
      logic [esld_pkg::EPOCH_W-1:0]  epoch;
      logic [esld_pkg::ZONE_W-1:0]   zone;
      logic                          given;
      local_time_type                want;
   } probe_row_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [esld_pkg::EPOCH_W-1:0]   req_epoch_seconds = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_ok;
   logic [esld_pkg::YEAR_W-1:0]    rsp_year;
   logic [esld_pkg::MONTH_W-1:0]   rsp_month;
   logic [esld_pkg::DOM_W-1:0]     rsp_day_of_month;
   logic [esld_pkg::HOUR_W-1:0]    rsp_hour;
   logic [esld_pkg::MIN_W-1:0]     rsp_minute;
   logic [esld_pkg::SEC_W-1:0]     rsp_second;
   logic                           csr_wr_en = 1'b0;
   logic [esld_pkg::ZONE_W-1:0]    csr_wr_data = '0;

   local_time_type                 pending_times [$];
   probe_row_type                  probes [0:N_PROBES-1];
   logic [esld_pkg::ZONE_W-1:0]    zone_bits = '0;
   bit                             hold_req = 1'b0;
   int unsigned                    cycle_count = 0;
   int                             fail_count = 0;
   int                             words_sent = 0;
   int                             in_range_count = 0;
   int                             out_range_count = 0;
   int                             zones_written = 0;
   int                             hold_left = 0;
   int                             pattern_left = 0;
   int                             stall_pct = 0;

   epoch_seconds_to_local_datetime_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_epoch_seconds(req_epoch_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Calendar helpers for the predictor
   function automatic bit is_leap(input int unsigned y);
      return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_year(input int unsigned y);
      return is_leap(y) ? 366 : 365;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      int unsigned n;
      case (m)
         2:           n = is_leap(y) ? 29 : 28;
         4, 6, 9, 11: n = 30;
         default:     n = 31;
      endcase
      return n;
   endfunction

   // Shift by the zone, split into days and seconds, then walk years and months
   function automatic local_time_type to_local_time(input logic [31:0] epoch,
                                                    input logic [16:0] zone);
      local_time_type r;
      logic [31:0] shifted;
      int unsigned days, sod, y, m, left;
      r = '0;
      shifted = epoch + {{15{zone[16]}}, zone};
      days = shifted / esld_pkg::SECS_PER_DAY;
      sod = shifted % esld_pkg::SECS_PER_DAY;
      if (days >= esld_pkg::DAY_LIMIT) return r;
      y = 1970;
      left = days;
      while (left >= days_in_year(y)) begin
         left -= days_in_year(y);
         y++;
      end
      m = 1;
      while (left >= days_in_month(y, m)) begin
         left -= days_in_month(y, m);
         m++;
      end
      r.ok = 1'b1;
      r.year = 12'(y);
      r.month = 4'(m);
      r.day_of_month = 5'(left + 1);
      r.hour = 5'(sod / 3600);
      r.minute = 6'((sod / 60) % 60);
      r.second = 6'(sod % 60);
      return r;
   endfunction

   // Mostly in-range stamps, with wraps, the range edge and day edges mixed in
   function automatic logic [31:0] pick_epoch();
      int unsigned sel;
      logic [31:0] e;
      sel = $urandom_range(0, 99);
      if (sel < 55)
         e = $urandom_range(0, LAST_OK_SEC);
      else if (sel < 70)
         e = $urandom;
      else if (sel < 80)
         e = LIMIT_SEC + $urandom_range(0, 200000) - 100000;
      else if (sel < 90)
         e = $urandom_range(0, 200000);
      else
         e = $urandom_range(0, esld_pkg::DAY_LIMIT - 1) * esld_pkg::SECS_PER_DAY
             + ($urandom_range(0, 1) ? $urandom_range(0, 2) : 86397 + $urandom_range(0, 2));
      return e;
   endfunction

   function automatic logic [16:0] zone_for_phase(input int ph);
      logic [16:0] z;
      case (ph)
         0:       z = 17'(-50400);
         1:       z = 17'(50400);
         2:       z = 17'h0FFFF;
         3:       z = 17'h10000;
         4:       z = 17'($urandom_range(0, 100800) - 50400);
         5:       z = 17'($urandom);
         6:       z = 17'h1FFFF;
         default: z = 17'd0;
      endcase
      return z;
   endfunction

   // Offer one word and hold it until taken; the answer is queued on acceptance
   task automatic send_word(input logic [31:0] e, input bit given, input local_time_type want);
      req_valid <= 1'b1;
      req_epoch_seconds <= e;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_times.push_back(given ? want : to_local_time(e, zone_bits));
      words_sent++;
   endtask

   // Zone change only with the pipe empty
   task automatic write_zone(input logic [16:0] z);
      req_valid <= 1'b0;
      while (pending_times.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= z;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      zone_bits = z;
      zones_written++;
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_word();
      local_time_type got, want;
      got = {rsp_ok, rsp_year, rsp_month, rsp_day_of_month, rsp_hour, rsp_minute, rsp_second};
      if (pending_times.size() == 0) begin
         $error("result word with nothing expected");
         fail_count++;
         return;
      end
      want = pending_times.pop_front();
      if (got.ok) in_range_count++;
      else out_range_count++;
      check_field("ok", 32'(want.ok), 32'(got.ok));
      check_field("year", 32'(want.year), 32'(got.year));
      check_field("month", 32'(want.month), 32'(got.month));
      check_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
      check_field("hour", 32'(want.hour), 32'(got.hour));
      check_field("minute", 32'(want.minute), 32'(got.minute));
      check_field("second", 32'(want.second), 32'(got.second));
   endtask

   // Receiver: check accepted words, stall on a shifting duty, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_word();
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 20;
                  2:       stall_pct = 50;
                  default: stall_pct = 85;
               endcase
               pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int k, n, burst;
      bit no_gap;

      // Directed probes, grouped by zone offset
      probes = '{
         '{32'd0,          17'd0,        1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
         '{32'd86399,      17'd0,        1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
         '{32'd86400,      17'd0,        1'b1, '{1'b1, 12'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0}},
         '{32'd68169600,   17'd0,        1'b0, '0},
         '{32'd951782400,  17'd0,        1'b0, '0},
         '{32'd2144447999, 17'd0,        1'b0, '0},
         '{32'd2144448000, 17'd0,        1'b1, '0},
         '{32'h7FFFFFFF,   17'd0,        1'b0, '0},
         '{32'hFFFFFFFF,   17'd0,        1'b1, '0},
         '{32'h55555555,   17'd0,        1'b0, '0},
         '{32'hAAAAAAAA,   17'd0,        1'b0, '0},
         '{32'd0,          17'h1FFFF,    1'b1, '0},
         '{32'd86400,      17'h1FFFF,    1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59}},
         '{32'd50400,      17'(-50400),  1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
         '{32'd0,          17'(-50400),  1'b1, '0},
         '{32'd0,          17'd50400,    1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1, 5'd14, 6'd0, 6'd0}},
         '{32'hFFFFFFFF,   17'd50400,    1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1, 5'd13, 6'd59, 6'd59}},
         '{32'd2144447999, 17'd50400,    1'b1, '0},
         '{32'd0,          17'h0FFFF,    1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1, 5'd18, 6'd12, 6'd15}},
         '{32'd65536,      17'h10000,    1'b1, '{1'b1, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}},
         '{32'd0,          17'h10000,    1'b1, '0},
         '{32'd1234567890, 17'h10000,    1'b0, '0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_zone(17'd0);

      for (k = 0; k < N_PROBES; k++) begin
         if (probes[k].zone != zone_bits) write_zone(probes[k].zone);
         send_word(probes[k].epoch, probes[k].given, probes[k].want);
      end

      // Random phases, one zone offset each; phase 1 opens with the long hold-off
      for (k = 0; k < N_PHASES; k++) begin
         write_zone(zone_for_phase(k));
         if (k == 1) hold_req = 1'b1;
         n = 0;
         while (n < PHASE_WORDS) begin
            burst = $urandom_range(1, 24);
            no_gap = (k == 1 && n < 60);
            while (burst > 0 && n < PHASE_WORDS) begin
               send_word(pick_epoch(), 1'b0, '0);
               burst--;
               n++;
            end
            if (!no_gap && $urandom_range(0, 3) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 9)) @(posedge clock);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_times.size() != 0) @(posedge clock);
      repeat (esld_pkg::NSTG + 8) @(posedge clock);
      if (pending_times.size() != 0) begin
         $error("%0d expected words never arrived", pending_times.size());
         fail_count++;
      end

      $display("%0d timestamps converted across %0d zone offset writes",
               words_sent, zones_written);
      $display("%0d dates in range, %0d beyond the day limit", in_range_count, out_range_count);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
